// File: src/uart_tx_rx_ring_buffers_defines.svh
// ---------------------------------------------------------------------------
// UART ring buffer assertion macros
// Shared concurrent assertion wrappers for the UART ring buffer block.
// ---------------------------------------------------------------------------
`ifndef UART_TX_RX_RING_BUFFERS_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_DEFINES_SVH

// checked only out of reset
`define UTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UTRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/utrb_pkg.sv
// ---------------------------------------------------------------------------
// UART ring buffer package
// Event codes, the tab terminator and the transaction structs.
// ---------------------------------------------------------------------------
package utrb_pkg;

  typedef enum logic [1:0] {
    ACT_APP_WRITE = 2'd0,
    ACT_TX_DONE   = 2'd1,
    ACT_RX_BYTE   = 2'd2,
    ACT_APP_READ  = 2'd3
  } action_t;

  localparam logic [7:0] TAB_CHAR = 8'h09;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       tx_ready;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_is_tab;
    logic       write_overflow;
    logic       receive_dropped;
  } out_t;

endpackage

// File: src/uart_tx_rx_ring_buffers.sv
// ---------------------------------------------------------------------------
// UART transmit/receive ring buffers
// Two byte rings in front of a serial transmitter and receiver; one event
// per transaction, one result per event.
// ---------------------------------------------------------------------------
// channel   handshake            payload
// input     start, busy          in_item  (utrb_pkg::in_t)
// result    out_strobe           out_result (utrb_pkg::out_t)
//
// One event is taken every cycle; busy is always low.
// The result appears in the cycle after the event, for one cycle.
// Latency is set by the registered read port of each byte store.
// Reset clears the ring pointers, the strobe and the result flags; the stores are not cleared.
// The receiver cannot stall; nothing is held back.
`include "uart_tx_rx_ring_buffers_defines.svh"

module uart_tx_rx_ring_buffers #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  utrb_pkg::in_t  in_item,
  output logic           out_strobe,
  output utrb_pkg::out_t out_result
);
  import utrb_pkg::*;

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [7:0]    snd_mem [DEPTH];
  logic [7:0]    rcv_mem [DEPTH];

  logic [PW-1:0] snd_head_r, snd_head_nxt, snd_tail_r, snd_tail_nxt;
  logic [PW-1:0] rcv_head_r, rcv_head_nxt, rcv_tail_r, rcv_tail_nxt;
  logic [PW-1:0] snd_tail_inc, rcv_tail_inc;

  logic          accept;
  logic          snd_full, snd_empty, rcv_full, rcv_empty;
  logic          snd_we, rcv_we;

  logic          out_strobe_r;
  logic          send_v_r, send_v_nxt;
  logic          send_q_r, send_q_nxt;
  logic          read_v_r, read_v_nxt;
  logic          ovf_r, ovf_nxt;
  logic          drop_r, drop_nxt;
  logic [7:0]    byte_r;
  logic [7:0]    snd_rdata_r, rcv_rdata_r;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign snd_tail_inc = ring_next(snd_tail_r);
  assign rcv_tail_inc = ring_next(rcv_tail_r);
  assign snd_full     = (snd_tail_inc == snd_head_r);
  assign rcv_full     = (rcv_tail_inc == rcv_head_r);
  assign snd_empty    = (snd_head_r == snd_tail_r);
  assign rcv_empty    = (rcv_head_r == rcv_tail_r);

  always_comb begin
    snd_head_nxt = snd_head_r;
    snd_tail_nxt = snd_tail_r;
    rcv_head_nxt = rcv_head_r;
    rcv_tail_nxt = rcv_tail_r;
    snd_we       = 1'b0;
    rcv_we       = 1'b0;
    send_v_nxt   = 1'b0;
    send_q_nxt   = 1'b0;
    read_v_nxt   = 1'b0;
    ovf_nxt      = 1'b0;
    drop_nxt     = 1'b0;
    if (accept) begin
      unique case (action_t'(in_item.action))
        ACT_APP_WRITE: begin
          if (in_item.tx_ready) begin
            send_v_nxt = 1'b1;
          end else if (snd_full) begin
            ovf_nxt = 1'b1;
          end else begin
            snd_we       = 1'b1;
            snd_tail_nxt = snd_tail_inc;
          end
        end
        ACT_TX_DONE: begin
          if (!snd_empty) begin
            send_v_nxt   = 1'b1;
            send_q_nxt   = 1'b1;
            snd_head_nxt = ring_next(snd_head_r);
          end
        end
        ACT_RX_BYTE: begin
          if (rcv_full) begin
            drop_nxt = 1'b1;
          end else begin
            rcv_we       = 1'b1;
            rcv_tail_nxt = rcv_tail_inc;
          end
        end
        ACT_APP_READ: begin
          if (!rcv_empty) begin
            read_v_nxt   = 1'b1;
            rcv_head_nxt = ring_next(rcv_head_r);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snd_head_r   <= '0;
      snd_tail_r   <= '0;
      rcv_head_r   <= '0;
      rcv_tail_r   <= '0;
      out_strobe_r <= 1'b0;
      send_v_r     <= 1'b0;
      send_q_r     <= 1'b0;
      read_v_r     <= 1'b0;
      ovf_r        <= 1'b0;
      drop_r       <= 1'b0;
    end else begin
      snd_head_r   <= snd_head_nxt;
      snd_tail_r   <= snd_tail_nxt;
      rcv_head_r   <= rcv_head_nxt;
      rcv_tail_r   <= rcv_tail_nxt;
      out_strobe_r <= accept;
      send_v_r     <= send_v_nxt;
      send_q_r     <= send_q_nxt;
      read_v_r     <= read_v_nxt;
      ovf_r        <= ovf_nxt;
      drop_r       <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= in_item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (snd_we) begin
      snd_mem[snd_tail_r] <= in_item.data_byte;
    end
    snd_rdata_r <= snd_mem[snd_head_r];
  end

  always_ff @(posedge clk) begin
    if (rcv_we) begin
      rcv_mem[rcv_tail_r] <= in_item.data_byte;
    end
    rcv_rdata_r <= rcv_mem[rcv_head_r];
  end

  assign out_strobe                 = out_strobe_r;
  assign out_result.send_valid      = send_v_r;
  assign out_result.send_byte       = !send_v_r ? 8'h00 : (send_q_r ? snd_rdata_r : byte_r);
  assign out_result.read_valid      = read_v_r;
  assign out_result.read_byte       = read_v_r ? rcv_rdata_r : 8'h00;
  assign out_result.read_is_tab     = read_v_r && (rcv_rdata_r == TAB_CHAR);
  assign out_result.write_overflow  = ovf_r;
  assign out_result.receive_dropped = drop_r;

  `UTRB_ASSERT(a_result_follows_accept, accept |=> out_strobe, "event gave no result")
  `UTRB_ASSERT(a_no_spurious_result, !accept |=> !out_strobe, "result without an event")
  `UTRB_ASSERT(a_overflow_when_full, out_result.write_overflow |-> $past(snd_full),
               "write dropped while send ring had room")
  `UTRB_ASSERT(a_drop_when_full, out_result.receive_dropped |-> $past(rcv_full),
               "received byte dropped while receive ring had room")
  `UTRB_ASSERT(a_flags_exclusive,
               $onehot0({out_result.send_valid, out_result.read_valid,
                         out_result.write_overflow, out_result.receive_dropped}),
               "more than one event flag in one result")
  `UTRB_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule
